@@ sv/fmprl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprl_pkg
// Types, constants and field-decode functions for the FM patch register-list
// decoder.
// ----------------------------------------------------------------------------
package fmprl_pkg;

	localparam int CNT_W = 18;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// allowed address space and register rows
	localparam logic [7:0] ADDR_OP_LO    = 8'h30;
	localparam logic [7:0] ADDR_OP_HI    = 8'h9F;
	localparam logic [7:0] ADDR_LOW_MASK = 8'h03;
	localparam logic [7:0] ADDR_ALGO     = 8'hB0;
	localparam logic [7:0] ADDR_FMS      = 8'hB4;

	localparam logic [3:0] ROW_MUL_DT  = 4'h3;
	localparam logic [3:0] ROW_TL      = 4'h4;
	localparam logic [3:0] ROW_AR_KS   = 4'h5;
	localparam logic [3:0] ROW_DR_AM   = 4'h6;
	localparam logic [3:0] ROW_SR      = 4'h7;
	localparam logic [3:0] ROW_RR_SL   = 4'h8;
	localparam logic [3:0] ROW_SSG     = 4'h9;
	localparam logic [3:0] ROW_CHANNEL = 4'hB;

	// reserved-bit masks per row
	localparam logic [7:0] RSV_MASK_MSB  = 8'h80;
	localparam logic [7:0] RSV_MASK_AR   = 8'h20;
	localparam logic [7:0] RSV_MASK_DR   = 8'h60;
	localparam logic [7:0] RSV_MASK_SR   = 8'hE0;
	localparam logic [7:0] RSV_MASK_SSG  = 8'hF0;
	localparam logic [7:0] RSV_MASK_ALGO = 8'hC0;

	localparam logic KIND_PAIR   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_EMPTY         = 3'd1,
		ST_TOO_SMALL     = 3'd2,
		ST_SIZE_MISMATCH = 3'd3,
		ST_INVALID       = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		GRP_MUL_DT  = 4'd0,
		GRP_TL      = 4'd1,
		GRP_AR_KS   = 4'd2,
		GRP_DR_AM   = 4'd3,
		GRP_SR      = 4'd4,
		GRP_RR_SL   = 4'd5,
		GRP_SSG     = 4'd6,
		GRP_ALGO_FB = 4'd7,
		GRP_FMS_AMS = 4'd8
	} group_t;

	typedef struct packed {
		logic       result_kind;
		logic [2:0] status;
		logic [1:0] operator_index;
		logic [3:0] register_group;
		logic [6:0] low_field;
		logic [3:0] high_field;
		logic       flag_bit;
		logic       last_result;
	} result_t;

	function automatic logic addr_ok(input logic [7:0] a);
		logic ok;
		if (a >= ADDR_OP_LO && a <= ADDR_OP_HI) begin
			ok = ((a & ADDR_LOW_MASK) == 8'h00);
		end else begin
			ok = (a == ADDR_ALGO) || (a == ADDR_FMS);
		end
		return ok;
	endfunction

	function automatic logic val_ok(input logic [7:0] a, input logic [7:0] v);
		logic ok;
		case (a[7:4])
			ROW_MUL_DT:  ok = ((v & RSV_MASK_MSB) == 8'h00);
			ROW_TL:      ok = ((v & RSV_MASK_MSB) == 8'h00);
			ROW_AR_KS:   ok = ((v & RSV_MASK_AR) == 8'h00);
			ROW_DR_AM:   ok = ((v & RSV_MASK_DR) == 8'h00);
			ROW_SR:      ok = ((v & RSV_MASK_SR) == 8'h00);
			ROW_RR_SL:   ok = 1'b1;
			ROW_SSG:     ok = ((v & RSV_MASK_SSG) == 8'h00);
			ROW_CHANNEL: ok = (a != ADDR_ALGO) || ((v & RSV_MASK_ALGO) == 8'h00);
			default:     ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic result_t pair_fields(input logic [7:0] a, input logic [7:0] v);
		result_t r;
		r = '0;
		r.result_kind    = KIND_PAIR;
		r.status         = ST_OK;
		r.operator_index = a[3:2];
		case (a[7:4])
			ROW_MUL_DT: begin
				r.register_group = GRP_MUL_DT;
				r.low_field      = {3'b000, v[3:0]};
				r.high_field     = {1'b0, v[6:4]};
			end
			ROW_TL: begin
				r.register_group = GRP_TL;
				r.low_field      = v[6:0];
			end
			ROW_AR_KS: begin
				r.register_group = GRP_AR_KS;
				r.low_field      = {2'b00, v[4:0]};
				r.high_field     = {2'b00, v[7:6]};
			end
			ROW_DR_AM: begin
				r.register_group = GRP_DR_AM;
				r.low_field      = {2'b00, v[4:0]};
				r.flag_bit       = v[7];
			end
			ROW_SR: begin
				r.register_group = GRP_SR;
				r.low_field      = {2'b00, v[4:0]};
			end
			ROW_RR_SL: begin
				r.register_group = GRP_RR_SL;
				r.low_field      = {3'b000, v[3:0]};
				r.high_field     = v[7:4];
			end
			ROW_SSG: begin
				r.register_group = GRP_SSG;
				r.low_field      = {4'b0000, v[2:0]};
				r.flag_bit       = v[3];
			end
			default: begin
				r.operator_index = 2'd0;
				r.low_field      = {4'b0000, v[2:0]};
				if (a == ADDR_ALGO) begin
					r.register_group = GRP_ALGO_FB;
					r.high_field     = {1'b0, v[5:3]};
				end else begin
					r.register_group = GRP_FMS_AMS;
					r.high_field     = {2'b00, v[5:4]};
				end
			end
		endcase
		return r;
	endfunction

endpackage

@@ sv/fmprl_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprl_in_if
// Byte stream channel into the patch decoder.
// ----------------------------------------------------------------------------
interface fmprl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_only;
	logic       last;

	modport source (output valid, output data_byte, output end_only, output last,
		input ready);
	modport sink (input valid, input data_byte, input end_only, input last,
		output ready);
endinterface

@@ sv/fmprl_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprl_out_if
// Result channel out of the patch decoder.
// ----------------------------------------------------------------------------
interface fmprl_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [2:0] status;
	logic [1:0] operator_index;
	logic [3:0] register_group;
	logic [6:0] low_field;
	logic [3:0] high_field;
	logic       flag_bit;
	logic       last_result;

	modport source (output valid, output result_kind, output status,
		output operator_index, output register_group, output low_field,
		output high_field, output flag_bit, output last_result, input ready);
	modport sink (input valid, input result_kind, input status,
		input operator_index, input register_group, input low_field,
		input high_field, input flag_bit, input last_result, output ready);
endinterface

@@ sv/fmprl_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprl_decode
// File state and per-byte checks; yields up to two results per byte.
// ----------------------------------------------------------------------------
module fmprl_decode
	import fmprl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       end_only,
	input  logic       last,
	output result_t    res0,
	output result_t    res1,
	output logic [1:0] res_cnt
);

	logic [CNT_W-1:0] byte_counter_q;
	logic [15:0]      pair_count_q;
	logic [7:0]       held_address_q;
	logic [8:0]       previous_address_q;
	logic             seen_algorithm_q;
	logic             list_error_q;

	logic [CNT_W-1:0] cnt_nxt;
	logic [15:0]      pc_nxt;
	logic [7:0]       ha_nxt;
	logic [8:0]       prev_nxt;
	logic             algo_nxt;
	logic             err_nxt;
	logic             cnt_sat;
	logic             pair_step;
	logic             pair_ok;
	logic             emit_pair;
	logic             file_end;
	logic [CNT_W-1:0] size;
	logic [15:0]      size_pc;
	logic [CNT_W-1:0] size_expect;
	logic             size_err;
	logic             size_algo;
	status_t          st;
	result_t          pair_r;
	result_t          stat_r;

	always_comb begin
		cnt_sat   = (byte_counter_q == CNT_MAX);
		pair_step = !end_only && !cnt_sat && (byte_counter_q >= CNT_W'(2))
			&& byte_counter_q[0];
		pc_nxt    = pair_count_q;
		ha_nxt    = held_address_q;
		if (!end_only && !cnt_sat) begin
			if (byte_counter_q == '0) begin
				pc_nxt = {data_byte, 8'h00};
			end else if (byte_counter_q == CNT_W'(1)) begin
				pc_nxt = {pair_count_q[15:8], data_byte};
			end else if (!byte_counter_q[0]) begin
				ha_nxt = data_byte;
			end
		end
		cnt_nxt = (end_only || cnt_sat) ? byte_counter_q : byte_counter_q + CNT_W'(1);

		pair_ok = (previous_address_q[8] || (held_address_q > previous_address_q[7:0]))
			&& addr_ok(held_address_q) && val_ok(held_address_q, data_byte);
		err_nxt   = list_error_q || (!end_only && cnt_sat) || (pair_step && !pair_ok);
		emit_pair = pair_step && !err_nxt;
		algo_nxt  = seen_algorithm_q || (pair_step && (held_address_q == ADDR_ALGO));
		prev_nxt  = pair_step ? {1'b0, held_address_q} : previous_address_q;

		// final status from the state as it stands after this byte
		size        = end_only ? byte_counter_q : cnt_nxt;
		size_pc     = end_only ? pair_count_q : pc_nxt;
		size_err    = end_only ? list_error_q : err_nxt;
		size_algo   = end_only ? seen_algorithm_q : algo_nxt;
		size_expect = {1'b0, size_pc, 1'b0} + CNT_W'(2);
		if (end_only && size == '0) begin
			st = ST_EMPTY;
		end else if (size < CNT_W'(4)) begin
			st = ST_TOO_SMALL;
		end else if (size_pc == 16'h0000 || size != size_expect) begin
			st = ST_SIZE_MISMATCH;
		end else if (size_err || !size_algo) begin
			st = ST_INVALID;
		end else begin
			st = ST_OK;
		end

		stat_r             = '0;
		stat_r.result_kind = KIND_STATUS;
		stat_r.status      = st;
		stat_r.last_result = 1'b1;
		pair_r             = pair_fields(held_address_q, data_byte);

		file_end = end_only || last;
		res0     = emit_pair ? pair_r : stat_r;
		res1     = stat_r;
		res_cnt  = 2'({1'b0, emit_pair} + {1'b0, file_end});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_counter_q     <= '0;
			pair_count_q       <= '0;
			held_address_q     <= '0;
			previous_address_q <= 9'h100;
			seen_algorithm_q   <= 1'b0;
			list_error_q       <= 1'b0;
		end else if (take) begin
			if (file_end) begin
				byte_counter_q     <= '0;
				pair_count_q       <= '0;
				held_address_q     <= '0;
				previous_address_q <= 9'h100;
				seen_algorithm_q   <= 1'b0;
				list_error_q       <= 1'b0;
			end else begin
				byte_counter_q     <= cnt_nxt;
				pair_count_q       <= pc_nxt;
				held_address_q     <= ha_nxt;
				previous_address_q <= prev_nxt;
				seen_algorithm_q   <= algo_nxt;
				list_error_q       <= err_nxt;
			end
		end
	end

endmodule

@@ sv/fmprl_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprl_outq
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module fmprl_outq
	import fmprl_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  result_t    wr0,
	input  result_t    wr1,
	input  logic [1:0] wr_cnt,
	output logic       room2,
	output logic       rd_valid,
	input  logic       rd_ready,
	output result_t    rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_ptr1;
	logic [PW-1:0]   wr_ptr2;
	logic            pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + PW'(1);
	endfunction

	always_comb begin
		wr_ptr1  = ptr_inc(wr_ptr_q);
		wr_ptr2  = ptr_inc(wr_ptr1);
		rd_valid = (count_q != '0);
		rd_data  = mem_q[rd_ptr_q];
		pop      = rd_valid && rd_ready;
		room2    = (count_q + CW'(2)) <= CW'(DEPTH);
	end

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr0;
		end
		if (wr_cnt == 2'd2) begin
			mem_q[wr_ptr1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (wr_cnt)
				2'd1:    wr_ptr_q <= wr_ptr1;
				2'd2:    wr_ptr_q <= wr_ptr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(wr_cnt) - CW'(pop);
		end
	end

endmodule

@@ sv/fm_patch_register_list_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_patch_register_list_decoder
// Streaming decoder for FM patch register lists with per-pair checks and a
// final file status.
// ----------------------------------------------------------------------------
// The block takes one file byte per transfer, every cycle, and checks each
// register/value pair as its value byte arrives: a good pair is split into
// operator, group and fields and queued in the same cycle, and the last byte
// (or an end-only transfer) queues the file status right behind it. Results
// leave the queue one per cycle while ready is high, at the earliest in the
// cycle after the byte: it is decoded and queued at the edge that takes it,
// and the queue head drives the result channel from its register in the next
// cycle. Since a byte can produce two results, the input is held off whenever
// the queue cannot take two more, so the byte rate is one per cycle as long
// as the result side keeps up, set by the single-read result queue. After the
// status the file state is back at reset and the next file may follow at once.
// ----------------------------------------------------------------------------
module fm_patch_register_list_decoder
	import fmprl_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	fmprl_in_if.sink   patch,
	fmprl_out_if.source result
);

	result_t    res0;
	result_t    res1;
	logic [1:0] res_cnt;
	logic [1:0] push_cnt;
	logic       take;
	logic       room2;
	result_t    head;

	// a transfer is taken only while the queue has space for a pair and a status
	assign patch.ready = room2;
	assign take        = patch.valid && room2;
	assign push_cnt    = take ? res_cnt : 2'd0;

	fmprl_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (patch.data_byte),
		.end_only  (patch.end_only),
		.last      (patch.last),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt)
	);

	fmprl_outq #(
		.DEPTH (QUEUE_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr0      (res0),
		.wr1      (res1),
		.wr_cnt   (push_cnt),
		.room2    (room2),
		.rd_valid (result.valid),
		.rd_ready (result.ready),
		.rd_data  (head)
	);

	// unpack the head of the queue onto the result channel
	assign result.result_kind    = head.result_kind;
	assign result.status         = head.status;
	assign result.operator_index = head.operator_index;
	assign result.register_group = head.register_group;
	assign result.low_field      = head.low_field;
	assign result.high_field     = head.high_field;
	assign result.flag_bit       = head.flag_bit;
	assign result.last_result    = head.last_result;

endmodule

@@ bench/tb_fm_patch_register_list_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fm_patch_register_list_decoder
// Self-checking bench for the FM patch register-list decoder.
// ----------------------------------------------------------------------------
// Patch files are streamed into the decoder one byte per transfer. Each
// accepted byte is run through a bench-side decoder that keeps its own file
// state, and the pair and status results that it works out are queued. A
// monitor pops the oldest queued result for every result transfer and checks
// it field by field. Directed files cover empty and short files, a zero pair
// count, a patch that uses every register group at its widest legal values,
// broken lists, trailing pairs, files closed by an end marker and a long
// result stall. Random patches follow, mostly well formed with random
// content, some damaged, some plain noise, with random idle gaps on both
// sides of the block.
// ----------------------------------------------------------------------------
module tb_fm_patch_register_list_decoder;
	import fmprl_pkg::*;

	localparam int STALL_LIMIT = 2000;   // cycles without any transfer
	localparam int DRAIN_CYCLES = 16;    // settle time after the last result
	localparam int RANDOM_ITEMS = 1580;
	localparam int PRESSURE_HOLD = 60;
	localparam logic [8:0] NO_PREV_ADDR = 9'h100;

	// how a file is closed: by last on its final byte, by an end-only marker,
	// or by a marker that also carries last
	typedef enum logic [1:0] {
		CLOSE_ON_LAST,
		CLOSE_WITH_MARK,
		CLOSE_MARK_AND_LAST
	} file_close_t;

	logic clk;
	logic arst_n;

	fmprl_in_if  patch_ch ();
	fmprl_out_if result_ch ();

	fm_patch_register_list_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.patch  (patch_ch),
		.result (result_ch)
	);

	// bench-side copy of the decoder's file state
	logic [CNT_W-1:0] byte_cnt;
	logic [15:0]      pair_cnt;
	logic [7:0]       held_addr;
	logic [8:0]       prev_addr;
	logic             seen_algo;
	logic             list_err;

	result_t    results_due[$];   // decoded pairs and file statuses still to come
	logic [7:0] file_bytes[$];    // file being assembled by a test

	int mismatch_count;
	int items_sent;
	int files_sent;
	int results_checked;

	// idle control, shared between the tests and the two driver processes
	bit source_gaps_on;
	bit sink_stalls_on;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// operator rows take addresses with bits 1:0 clear; above them only the
	// algorithm and the fms/ams register
	function automatic bit reg_addr_legal(input logic [7:0] a);
		if (a >= ADDR_OP_LO && a <= ADDR_OP_HI)
			return (a & ADDR_LOW_MASK) == 8'h00;
		return a == ADDR_ALGO || a == ADDR_FMS;
	endfunction

	// value bits a register may use; all others are reserved
	function automatic logic [7:0] legal_value_mask(input logic [7:0] a);
		case (a[7:4])
			ROW_MUL_DT, ROW_TL: return ~RSV_MASK_MSB;
			ROW_AR_KS:          return ~RSV_MASK_AR;
			ROW_DR_AM:          return ~RSV_MASK_DR;
			ROW_SR:             return ~RSV_MASK_SR;
			ROW_RR_SL:          return 8'hFF;
			ROW_SSG:            return ~RSV_MASK_SSG;
			ROW_CHANNEL:        return (a == ADDR_ALGO) ? ~RSV_MASK_ALGO : 8'hFF;
			default:            return 8'h00;
		endcase
	endfunction

	// split one register write into group, operator and fields
	function automatic result_t split_pair(input logic [7:0] a, input logic [7:0] v);
		result_t r;
		group_t  grp;
		logic [7:0] lo, hi, fl;
		logic [1:0] op;
		lo = 8'h00;
		hi = 8'h00;
		fl = 8'h00;
		op = a[3:2];
		case (a[7:4])
			ROW_MUL_DT: begin
				grp = GRP_MUL_DT;
				lo = v & 8'h0F;
				hi = (v >> 4) & 8'h07;
			end
			ROW_TL: begin
				grp = GRP_TL;
				lo = v & 8'h7F;
			end
			ROW_AR_KS: begin
				grp = GRP_AR_KS;
				lo = v & 8'h1F;
				hi = (v >> 6) & 8'h03;
			end
			ROW_DR_AM: begin
				grp = GRP_DR_AM;
				lo = v & 8'h1F;
				fl = (v >> 7) & 8'h01;
			end
			ROW_SR: begin
				grp = GRP_SR;
				lo = v & 8'h1F;
			end
			ROW_RR_SL: begin
				grp = GRP_RR_SL;
				lo = v & 8'h0F;
				hi = v >> 4;
			end
			ROW_SSG: begin
				grp = GRP_SSG;
				lo = v & 8'h07;
				fl = (v >> 3) & 8'h01;
			end
			default: begin
				// channel registers carry no operator slot
				op = 2'd0;
				lo = v & 8'h07;
				if (a == ADDR_ALGO) begin
					grp = GRP_ALGO_FB;
					hi = (v >> 3) & 8'h07;
				end else begin
					grp = GRP_FMS_AMS;
					hi = (v >> 4) & 8'h03;
				end
			end
		endcase
		r = '0;
		r.result_kind    = KIND_PAIR;
		r.status         = ST_OK;
		r.operator_index = op;
		r.register_group = grp;
		r.low_field      = lo[6:0];
		r.high_field     = hi[3:0];
		r.flag_bit       = fl[0];
		return r;
	endfunction

	// file status from the current state, in priority order
	function automatic result_t file_status(input bit empty_end);
		result_t r;
		status_t st;
		int n;
		n = int'(byte_cnt);
		if (empty_end && n == 0)
			st = ST_EMPTY;
		else if (n < 4)
			st = ST_TOO_SMALL;
		else if (pair_cnt == 16'h0000 || n != 2 + 2 * int'(pair_cnt))
			st = ST_SIZE_MISMATCH;
		else if (list_err || !seen_algo)
			st = ST_INVALID;
		else
			st = ST_OK;
		r = '0;
		r.result_kind = KIND_STATUS;
		r.status      = st;
		r.last_result = 1'b1;
		return r;
	endfunction

	function automatic void clear_file_state();
		byte_cnt  = '0;
		pair_cnt  = '0;
		held_addr = '0;
		prev_addr = NO_PREV_ADDR;
		seen_algo = 1'b0;
		list_err  = 1'b0;
	endfunction

	// bench-side decode of one accepted byte; queues whatever it produces
	task automatic decode_patch_byte(input logic [7:0] b, input logic eo, input logic lst);
		logic [7:0] a;
		bit pair_ok;
		if (eo) begin
			// end marker wins over last and carries no byte
			results_due.push_back(file_status(1'b1));
			clear_file_state();
			return;
		end
		if (byte_cnt == CNT_MAX) begin
			// saturated counter: byte is dropped but poisons the list
			list_err = 1'b1;
		end else begin
			if (byte_cnt == 0) begin
				pair_cnt = {b, 8'h00};
			end else if (byte_cnt == 1) begin
				pair_cnt[7:0] = b;
			end else if (!byte_cnt[0]) begin
				held_addr = b;
			end else begin
				a = held_addr;
				pair_ok = (prev_addr == NO_PREV_ADDR || {1'b0, a} > prev_addr)
					&& reg_addr_legal(a) && ((b & ~legal_value_mask(a)) == 8'h00);
				prev_addr = {1'b0, a};
				if (a == ADDR_ALGO)
					seen_algo = 1'b1;
				if (!pair_ok)
					list_err = 1'b1;
				// pairs are only reported while the list is still clean
				if (!list_err)
					results_due.push_back(split_pair(a, b));
			end
			byte_cnt = byte_cnt + 1'b1;
		end
		if (lst) begin
			results_due.push_back(file_status(1'b0));
			clear_file_state();
		end
	endtask

	// one byte transfer: optional idle gap, offer at the falling edge, hold
	// until the block takes it at a rising edge
	task automatic send_item(input logic [7:0] b, input logic eo, input logic lst);
		int gap;
		gap = source_gaps_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			patch_ch.valid <= 1'b0;
		end
		@(negedge clk);
		patch_ch.valid     <= 1'b1;
		patch_ch.data_byte <= b;
		patch_ch.end_only  <= eo;
		patch_ch.last      <= lst;
		do
			@(posedge clk);
		while (!patch_ch.ready);
		decode_patch_byte(b, eo, lst);
		items_sent++;
	endtask

	// stream file_bytes and close the file as asked; an empty file always
	// needs the end marker
	task automatic send_file(input file_close_t close);
		int last_idx;
		last_idx = file_bytes.size() - 1;
		foreach (file_bytes[i])
			send_item(file_bytes[i], 1'b0, close == CLOSE_ON_LAST && i == last_idx);
		if (close != CLOSE_ON_LAST || file_bytes.size() == 0)
			send_item(8'($urandom), 1'b1, close == CLOSE_MARK_AND_LAST);
		files_sent++;
	endtask

	// well-formed patch: rising legal addresses, reserved bits clear, count
	// matching the pairs
	task automatic build_patch(input int keep_pct, input bit with_algo);
		int a;
		int pairs;
		bit take;
		logic [7:0] mask;
		logic [7:0] v;
		file_bytes.delete();
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'h00);
		pairs = 0;
		for (a = 'h30; a <= 'hB4; a += 4) begin
			take = reg_addr_legal(8'(a)) && ($urandom_range(0, 99) < keep_pct);
			if (8'(a) == ADDR_ALGO)
				take = with_algo;
			if (take) begin
				mask = legal_value_mask(8'(a));
				case ($urandom_range(0, 9))
					0:       v = 8'h00;
					1:       v = mask;
					default: v = 8'($urandom) & mask;
				endcase
				file_bytes.push_back(8'(a));
				file_bytes.push_back(v);
				pairs++;
			end
		end
		file_bytes[0] = 8'(pairs >> 8);
		file_bytes[1] = 8'(pairs);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// end marker alone, with and without last
	task automatic test_empty_files();
		file_bytes.delete();
		send_file(CLOSE_WITH_MARK);
		send_file(CLOSE_MARK_AND_LAST);
	endtask

	// one byte closed by last, three bytes closed by a marker
	task automatic test_short_files();
		file_bytes = {8'h00};
		send_file(CLOSE_ON_LAST);
		file_bytes = {8'h00, 8'h01, 8'h30};
		send_file(CLOSE_WITH_MARK);
	endtask

	// count zero with one good pair: the final byte yields pair plus status
	task automatic test_count_zero();
		file_bytes = {8'h00, 8'h00, 8'h30, 8'h71};
		send_file(CLOSE_ON_LAST);
	endtask

	// every register group, every operator slot, widest legal values
	task automatic test_full_patch();
		file_bytes = {8'h00, 8'h09,
			8'h30, 8'h7F, 8'h44, 8'h7F, 8'h58, 8'hDF, 8'h6C, 8'h9F,
			8'h70, 8'h1F, 8'h84, 8'hFF, 8'h98, 8'h0F, 8'hB0, 8'h3F, 8'hB4, 8'hFF};
		send_file(CLOSE_ON_LAST);
	endtask

	// missing algorithm, reserved bits, falling address, disallowed address
	task automatic test_list_errors();
		file_bytes = {8'h00, 8'h01, 8'h9C, 8'h0F};
		send_file(CLOSE_ON_LAST);
		file_bytes = {8'h00, 8'h01, 8'hB0, 8'hC0};
		send_file(CLOSE_ON_LAST);
		file_bytes = {8'h00, 8'h02, 8'h50, 8'h00, 8'h4C, 8'h00};
		send_file(CLOSE_ON_LAST);
		file_bytes = {8'h00, 8'h02, 8'hB0, 8'h00, 8'hB2, 8'h00};
		send_file(CLOSE_ON_LAST);
	endtask

	// a pair past the declared count is still decoded
	task automatic test_trailing_pairs();
		file_bytes = {8'h00, 8'h01, 8'hB0, 8'h07, 8'hB4, 8'hFF};
		send_file(CLOSE_ON_LAST);
	endtask

	// marker arriving with an address byte still held
	task automatic test_end_mark_mid_file();
		file_bytes = {8'h00, 8'h01, 8'hB0, 8'h00, 8'hB4};
		send_file(CLOSE_MARK_AND_LAST);
	endtask

	// receiver holds off while a full patch streams in back to back, so the
	// result queue fills and the byte input has to stall
	task automatic test_output_backpressure();
		source_gaps_on = 1'b0;
		hold_cycles = PRESSURE_HOLD;
		build_patch(100, 1'b1);
		send_file(CLOSE_ON_LAST);
		source_gaps_on = 1'b1;
	endtask

	// mostly legal patches, a share of damaged ones, and raw noise
	task automatic test_random_files();
		int target;
		int npairs;
		int j;
		int roll;
		file_close_t close;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			// some files run without any idling on one side or the other
			source_gaps_on = ($urandom_range(0, 4) != 0);
			sink_stalls_on = ($urandom_range(0, 4) != 0);
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				build_patch($urandom_range(5, 60), $urandom_range(0, 99) < 85);
				npairs = (file_bytes.size() - 2) / 2;
				j = (npairs > 0) ? $urandom_range(0, npairs - 1) : 0;
				if ($urandom_range(0, 99) < 30) begin
					case ($urandom_range(0, 5))
						0: if (npairs > 0) file_bytes[3 + 2 * j] = 8'($urandom);
						1: if (npairs > 0) file_bytes[2 + 2 * j] = 8'($urandom);
						2: if (j > 0) file_bytes[2 + 2 * j] = file_bytes[2 * j];
						3: file_bytes[1] = file_bytes[1] + ($urandom_range(0, 1) ? 8'h01 : 8'hFF);
						4: void'(file_bytes.pop_back());
						default: begin
							file_bytes.push_back(8'($urandom));
							file_bytes.push_back(8'($urandom));
						end
					endcase
				end
			end else begin
				file_bytes.delete();
				repeat ($urandom_range(0, 12))
					file_bytes.push_back(8'($urandom));
			end
			roll = $urandom_range(0, 99);
			if (roll < 80)
				close = CLOSE_ON_LAST;
			else if (roll < 95)
				close = CLOSE_WITH_MARK;
			else
				close = CLOSE_MARK_AND_LAST;
			send_file(close);
		end
		source_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// receiver: a requested hold-off first, then random stalls
	initial begin : result_sink
		int stall;
		stall = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
				if (sink_stalls_on)
					stall = pick_gap();
			end
		end
	end

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// every result transfer is matched against the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_checked++;
			if (results_due.size() == 0) begin
				$error("unexpected result: kind %0d status %0d group %0d",
					result_ch.result_kind, result_ch.status, result_ch.register_group);
				mismatch_count++;
			end else begin
				want = results_due.pop_front();
				compare_field("result_kind", want.result_kind, result_ch.result_kind);
				compare_field("status", want.status, result_ch.status);
				compare_field("operator_index", want.operator_index, result_ch.operator_index);
				compare_field("register_group", want.register_group, result_ch.register_group);
				compare_field("low_field", want.low_field, result_ch.low_field);
				compare_field("high_field", want.high_field, result_ch.high_field);
				compare_field("flag_bit", want.flag_bit, result_ch.flag_bit);
				compare_field("last_result", want.last_result, result_ch.last_result);
			end
		end
	end

	// watchdog: too long without a transfer on either side ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((patch_ch.valid && patch_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no transfer for %0d cycles, %0d results outstanding",
			STALL_LIMIT, results_due.size());
		$display("tb_fm_patch_register_list_decoder: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		arst_n             = 1'b0;
		patch_ch.valid     = 1'b0;
		patch_ch.data_byte = 8'h00;
		patch_ch.end_only  = 1'b0;
		patch_ch.last      = 1'b0;
		mismatch_count     = 0;
		items_sent         = 0;
		files_sent         = 0;
		results_checked    = 0;
		source_gaps_on     = 1'b1;
		sink_stalls_on     = 1'b1;
		hold_cycles        = 0;
		clear_file_state();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_files();
		test_short_files();
		test_count_zero();
		test_full_patch();
		test_list_errors();
		test_trailing_pairs();
		test_end_mark_mid_file();
		test_output_backpressure();
		test_random_files();

		// stop offering bytes, let the result queue drain, then watch for strays
		@(negedge clk);
		patch_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d files, %0d byte transfers, %0d results checked",
			files_sent, items_sent, results_checked);
		$display("incl. empty/short/broken lists, trailing pairs, end markers and a long stall");
		if (mismatch_count == 0)
			$display("tb_fm_patch_register_list_decoder: done, clean");
		else
			$display("tb_fm_patch_register_list_decoder: done, errors");
		$finish;
	end

endmodule
